// ----- design/prefix_trie_insert_search_macros.svh -----
// ----------------------------------------------------------------------------
// Prefix trie assertion macros
// Shared concurrent assertion wrappers, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef PREFIX_TRIE_INSERT_SEARCH_MACROS_SVH
`define PREFIX_TRIE_INSERT_SEARCH_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTIS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTIS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/ptis_pkg.sv -----
// ----------------------------------------------------------------------------
// Prefix trie package
// Sizes, command codes, controller states and the child table request type.
// ----------------------------------------------------------------------------
package ptis_pkg;

   // Node pool and alphabet
   localparam int MAX_NODES     = 256;
   localparam int ALPHABET_SIZE = 256;
   localparam int SYMBOL_W      = 8;

   localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SYM_IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int ADDR_W    = NODE_W + SYM_IDX_W;
   localparam int ENTRY_W   = NODE_W + 1;
   localparam int COUNT_W   = NODE_W + 1;
   localparam int TABLE_DEPTH = 1 << ADDR_W;

   // Command codes
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_PREFIX = 2'd2,
      CMD_NONE   = 2'd3
   } command_type;

   // Result status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_POOL_FULL = 1'b1;

   // Controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH
   } state_type;

   // Child table access from the controller
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] wdata;
   } ram_req_type;

endpackage

// ----- design/prefix_trie_insert_search.sv -----
// A symbol item is accepted in the idle state, which issues the child table read,
// and is then followed or allocated in the lookup state. A last item then passes
// the finish state, which loads the result into the output register. No new item
// is accepted until the previous one is done: its read picks the next cursor node.
// Reset: a clearing sweep over all 65536 entries zeroes the child table and the
// terminal marks; no transfer is accepted on req_ until it ends.
// ----------------------------------------------------------------------------
// Prefix trie insert and search
// Character trie in a bounded node pool, walked one symbol per transfer.
// ----------------------------------------------------------------------------
`include "prefix_trie_insert_search_macros.svh"

module prefix_trie_insert_search import ptis_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [SYMBOL_W-1:0] req_symbol,
   input  logic                req_symbol_present,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic                rsp_status,
   output logic [1:0]          rsp_done_command
);

   state_type          state_ff, state_in;
   logic [NODE_W-1:0]  cursor_ff, cursor_in;
   logic               missed_ff, missed_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] nodes_used_ff, nodes_used_in;
   command_type        cmd_ff, cmd_in;
   logic               last_ff, last_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [1:0]         rsp_cmd_ff, rsp_cmd_in;

   logic               term_mem [MAX_NODES];
   logic               term_rd_ff;
   logic [NODE_W-1:0]  term_clr_ff, term_clr_in;
   logic               term_wr_en;
   logic [NODE_W-1:0]  term_wr_addr;
   logic               term_wr_data;

   ram_req_type        ram_req;
   logic [ENTRY_W-1:0] rd_data;
   logic               clear_busy;

   command_type        req_cmd;
   logic               accept;
   logic               walk;
   logic               sym_ok;
   logic               lookup_go;
   logic               child_hit;
   logic               pool_full;
   logic               alloc;
   logic               rsp_load;
   logic               pool_in_range;
   logic               in_lookup;

   ptis_child_ram u_child_ram (
      .clock      (clock),
      .reset      (reset),
      .ram_req    (ram_req),
      .rd_data    (rd_data),
      .clear_busy (clear_busy)
   );

   // Decode the incoming transfer
   assign req_cmd   = command_type'(req_command);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign walk      = req_symbol_present && !missed_ff && (req_cmd != CMD_NONE);
   assign sym_ok    = (9'(req_symbol) < 9'(ALPHABET_SIZE));
   assign lookup_go = accept && walk && sym_ok;

   // Resolve the child lookup
   assign child_hit = (rd_data != '0);
   assign pool_full = (nodes_used_ff >= COUNT_W'(MAX_NODES));
   assign alloc     = (state_ff == ST_LOOKUP) && !child_hit && (cmd_ff == CMD_INSERT)
                      && !pool_full;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (lookup_go) begin
               state_in = ST_LOOKUP;
            end else if (accept && req_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_LOOKUP: begin
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and child table requests
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      ram_req.rd_en = lookup_go;
      ram_req.wr_en = alloc;
      ram_req.addr  = lookup_go ? {cursor_ff, req_symbol[SYM_IDX_W-1:0]} : addr_ff;
      ram_req.wdata = ENTRY_W'(nodes_used_ff + 1'b1);
   end

   // Terminal mark writes: sweep while the child table clears, then mark on insert
   always_comb begin
      term_clr_in  = term_clr_ff;
      term_wr_en   = 1'b0;
      term_wr_addr = cursor_ff;
      term_wr_data = 1'b1;
      if (state_ff == ST_CLEAR) begin
         term_clr_in  = term_clr_ff + 1'b1;
         term_wr_en   = 1'b1;
         term_wr_addr = term_clr_ff;
         term_wr_data = 1'b0;
      end else if (rsp_load && !missed_ff && (cmd_ff == CMD_INSERT)) begin
         term_wr_en = 1'b1;
      end
   end

   // Walk state, pool and result
   always_comb begin
      cursor_in     = cursor_ff;
      missed_in     = missed_ff;
      ovf_in        = ovf_ff;
      nodes_used_in = nodes_used_ff;
      cmd_in        = cmd_ff;
      last_in       = last_ff;
      addr_in       = addr_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;

      // Capture the transfer; mark an out-of-alphabet symbol as a miss
      if (accept) begin
         cmd_in  = req_cmd;
         last_in = req_last;
         addr_in = {cursor_ff, req_symbol[SYM_IDX_W-1:0]};
         if (walk && !sym_ok) begin
            missed_in = 1'b1;
            if (req_cmd == CMD_INSERT) ovf_in = 1'b1;
         end
      end

      // Follow, allocate or drop the word
      if (state_ff == ST_LOOKUP) begin
         if (child_hit) begin
            cursor_in = NODE_W'(rd_data - 1'b1);
         end else if (cmd_ff != CMD_INSERT) begin
            missed_in = 1'b1;
         end else if (pool_full) begin
            missed_in = 1'b1;
            ovf_in    = 1'b1;
         end else begin
            cursor_in     = nodes_used_ff[NODE_W-1:0];
            nodes_used_in = nodes_used_ff + 1'b1;
         end
      end

      // Close the word and load the result
      if (rsp_load) begin
         rsp_found_in  = 1'b0;
         rsp_status_in = ovf_ff ? STATUS_POOL_FULL : STATUS_OK;
         rsp_cmd_in    = cmd_ff;
         if (!missed_ff) begin
            case (cmd_ff)
               CMD_INSERT: rsp_found_in = 1'b0;
               CMD_SEARCH: rsp_found_in = term_rd_ff;
               CMD_PREFIX: rsp_found_in = 1'b1;
               default:    rsp_found_in = 1'b0;
            endcase
         end
         cursor_in = '0;
         missed_in = 1'b0;
         ovf_in    = 1'b0;
      end

      // Hold the result until its transfer
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Terminal marks: write, and read the mark of the next cursor node
   always_ff @(posedge clock) begin
      if (term_wr_en) begin
         term_mem[term_wr_addr] <= term_wr_data;
      end
      term_rd_ff <= term_mem[cursor_in];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cursor_ff     <= '0;
         missed_ff     <= 1'b0;
         ovf_ff        <= 1'b0;
         nodes_used_ff <= COUNT_W'(1);
         term_clr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         missed_ff     <= missed_in;
         ovf_ff        <= ovf_in;
         nodes_used_ff <= nodes_used_in;
         term_clr_ff   <= term_clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_ff       <= last_in;
      addr_ff       <= addr_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_done_command = rsp_cmd_ff;

   // Checks
   assign pool_in_range = (nodes_used_ff >= COUNT_W'(1))
                          && (nodes_used_ff <= COUNT_W'(MAX_NODES));
   assign in_lookup     = (state_ff == ST_LOOKUP) && !clear_busy;

   `PTIS_ASSERT(a_pool_bounds, pool_in_range, "node count out of range")
   `PTIS_ASSERT(a_cursor_alloc, COUNT_W'(cursor_ff) < nodes_used_ff, "cursor on unallocated node")
   `PTIS_ASSERT(a_write_in_lookup, ram_req.wr_en |-> in_lookup, "child write outside lookup")
   `PTIS_ASSERT(a_rsp_load, $rose(rsp_valid_ff) |-> $past(rsp_load), "result outside finish")

endmodule

// ----- design/ptis_child_ram.sv -----
// ----------------------------------------------------------------------------
// Prefix trie child table
// Single-port child table (entry = child node + 1, zero = no child) with a
// registered read and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module ptis_child_ram import ptis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ram_req_type        ram_req,
   output logic [ENTRY_W-1:0] rd_data,
   output logic               clear_busy
);

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic               clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]  clr_idx_ff, clr_idx_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // Advance the clearing sweep one entry a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (&clr_idx_ff) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // Select the write port: sweep first, then controller
   always_comb begin
      wr_en   = clr_busy_ff | ram_req.wr_en;
      wr_addr = clr_busy_ff ? clr_idx_ff : ram_req.addr;
      wr_data = clr_busy_ff ? '0 : ram_req.wdata;
   end

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ----- dv/prefix_trie_insert_search_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prefix trie insert and search testbench
// Streams words one symbol per transfer into the trie, mirrors the node pool
// and cursor walk in a local trie copy, and checks every word result in order.
// Both channels pause at random; the pool is driven past full mid-run.
// ----------------------------------------------------------------------------
module prefix_trie_insert_search_tb;
   import ptis_pkg::*;

   localparam int CYCLE_LIMIT = 800000;
   localparam int WORD_MAX    = 16;
   localparam int BANK_DEPTH  = 512;

   typedef struct packed {
      command_type         command;
      logic [SYMBOL_W-1:0] symbol;
      logic                present;
      logic                last;
   } trie_item_type;

   typedef struct packed {
      logic        found;
      logic        status;
      command_type done_command;
   } trie_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_command = CMD_INSERT;
   logic [SYMBOL_W-1:0] req_symbol = '0;
   logic                req_symbol_present = 1'b0;
   logic                req_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic                rsp_status;
   logic [1:0]          rsp_done_command;

   // Words waiting to go out and word results still owed by the block
   trie_item_type   symbol_queue [$];
   trie_result_type answers_due [$];

   // Local trie copy: child entry holds node+1, zero means no child
   logic [ENTRY_W-1:0] trie_child [TABLE_DEPTH] = '{default: '0};
   logic               trie_terminal [MAX_NODES] = '{default: 1'b0};
   int                 nodes_taken = 1;
   int                 walk_node = 0;
   bit                 walk_missed = 1'b0;
   bit                 walk_overflow = 1'b0;

   // Inserted words, kept so that searches can revisit them
   logic [7:0]          bank_sym [BANK_DEPTH][WORD_MAX];
   int                  bank_len [BANK_DEPTH];
   int                  bank_count = 0;
   logic [7:0]          word_buf [WORD_MAX];

   int                  items_made = 0;
   int                  items_accepted = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  gap_left = 0;
   int                  hold_left = 0;
   int                  req_calm = 0;
   int                  rsp_calm = 0;
   trie_item_type       on_wire;

   prefix_trie_insert_search DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_symbol         (req_symbol),
      .req_symbol_present (req_symbol_present),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_status         (rsp_status),
      .rsp_done_command   (rsp_done_command)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Pause length for one transfer, with occasional runs of back-to-back traffic
   function automatic int draw_pause(inout int calm_run);
      if (calm_run > 0) begin
         calm_run--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_run = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Advance the cursor by one symbol, allocating on insert
   task automatic trie_walk(input command_type cmd, input logic [SYMBOL_W-1:0] sym);
      int slot;
      if (walk_missed || cmd == CMD_NONE) return;
      if (int'(sym) >= ALPHABET_SIZE || walk_node >= MAX_NODES) begin
         walk_missed = 1'b1;
         if (cmd == CMD_INSERT) walk_overflow = 1'b1;
         return;
      end
      slot = walk_node * ALPHABET_SIZE + int'(sym);
      if (trie_child[slot] != '0) begin
         walk_node = int'(trie_child[slot]) - 1;
         return;
      end
      if (cmd != CMD_INSERT) begin
         walk_missed = 1'b1;
         return;
      end
      if (nodes_taken >= MAX_NODES) begin
         walk_missed = 1'b1;
         walk_overflow = 1'b1;
         return;
      end
      trie_child[slot] = ENTRY_W'(nodes_taken + 1);
      walk_node = nodes_taken;
      nodes_taken++;
   endtask

   // Apply one accepted transfer; a last item resolves the word and owes a result
   task automatic trie_accept(input trie_item_type it);
      trie_result_type res;
      if (it.present) trie_walk(it.command, it.symbol);
      if (!it.last) return;
      res.found = 1'b0;
      if (!walk_missed && walk_node < MAX_NODES) begin
         case (it.command)
            CMD_INSERT: trie_terminal[walk_node] = 1'b1;
            CMD_SEARCH: res.found = trie_terminal[walk_node];
            CMD_PREFIX: res.found = 1'b1;
            default: ;
         endcase
      end
      res.status       = walk_overflow ? STATUS_POOL_FULL : STATUS_OK;
      res.done_command = it.command;
      answers_due.push_back(res);
      walk_node     = 0;
      walk_missed   = 1'b0;
      walk_overflow = 1'b0;
   endtask

   task automatic push_item(input command_type cmd, input logic [7:0] sym,
                            input logic present, input logic last);
      trie_item_type it;
      it.command = cmd;
      it.symbol  = sym;
      it.present = present;
      it.last    = last;
      symbol_queue.push_back(it);
      items_made++;
   endtask

   // Queue the word in word_buf; an empty word is one item with no symbol
   task automatic push_word(input command_type cmd, input int len);
      if (len == 0) begin
         push_item(cmd, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
         return;
      end
      for (int k = 0; k < len; k++) push_item(cmd, word_buf[k], 1'b1, k == len - 1);
   endtask

   task automatic bank_word(input int len);
      int idx;
      if (bank_count < BANK_DEPTH) begin
         idx = bank_count;
         bank_count++;
      end else begin
         idx = $urandom_range(0, BANK_DEPTH - 1);
      end
      for (int k = 0; k < WORD_MAX; k++) bank_sym[idx][k] = word_buf[k];
      bank_len[idx] = len;
   endtask

   function automatic int recall_word();
      int idx;
      idx = $urandom_range(0, bank_count - 1);
      for (int k = 0; k < WORD_MAX; k++) word_buf[k] = bank_sym[idx][k];
      return bank_len[idx];
   endfunction

   function automatic logic [7:0] narrow_symbol();
      return 8'h61 + 8'($urandom_range(0, 3));
   endfunction

   // Driver: hold a stalled item, otherwise pause or present the next one
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            trie_accept(on_wire);
            items_accepted++;
            gap_left = draw_pause(req_calm);
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left == 0 && symbol_queue.size() != 0) begin
               on_wire = symbol_queue.pop_front();
               req_valid          <= 1'b1;
               req_command        <= on_wire.command;
               req_symbol         <= on_wire.symbol;
               req_symbol_present <= on_wire.present;
               req_last           <= on_wire.last;
            end else begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest owed result
   always @(posedge clock) begin : monitor
      trie_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result found=%0b status=%0b command=%0d",
                        $time, rsp_found, rsp_status, rsp_done_command);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0b actual %0b",
                           $time, want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_done_command !== want.done_command) begin
                  $display("%0t: done_command expected %0d actual %0d",
                           $time, want.done_command, rsp_done_command);
                  mismatch_count++;
               end
            end
            hold_left = draw_pause(rsp_calm);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("prefix_trie_insert_search: mismatch");
         $finish;
      end
   end

   initial begin
      int len;
      int pick;
      bit pool_filled;

      pool_filled = 1'b0;

      // Empty words at the root: search misses before the root is terminal, then hits
      push_item(CMD_SEARCH, 8'h00, 1'b0, 1'b1);
      push_item(CMD_PREFIX, 8'hFF, 1'b0, 1'b1);
      push_item(CMD_INSERT, 8'hA5, 1'b0, 1'b1);
      push_item(CMD_SEARCH, 8'h5A, 1'b0, 1'b1);
      // Extreme symbols: full word hits, its prefix is a path but not a word
      push_item(CMD_INSERT, 8'h00, 1'b1, 1'b0);
      push_item(CMD_INSERT, 8'hFF, 1'b1, 1'b1);
      push_item(CMD_SEARCH, 8'h00, 1'b1, 1'b0);
      push_item(CMD_SEARCH, 8'hFF, 1'b1, 1'b1);
      push_item(CMD_SEARCH, 8'h00, 1'b1, 1'b1);
      push_item(CMD_PREFIX, 8'h00, 1'b1, 1'b1);
      // Broken path: later symbols are ignored even where a path resumes
      push_item(CMD_SEARCH, 8'hFF, 1'b1, 1'b0);
      push_item(CMD_SEARCH, 8'h00, 1'b1, 1'b0);
      push_item(CMD_PREFIX, 8'hFF, 1'b1, 1'b1);
      // Item with no symbol inside a word moves nothing
      push_item(CMD_PREFIX, 8'h00, 1'b1, 1'b0);
      push_item(CMD_PREFIX, 8'h3C, 1'b0, 1'b0);
      push_item(CMD_PREFIX, 8'hFF, 1'b1, 1'b1);
      // Mixed commands: insert allocates, the search on the last item misses
      push_item(CMD_INSERT, 8'h55, 1'b1, 1'b0);
      push_item(CMD_SEARCH, 8'hAA, 1'b1, 1'b1);
      // Idle command words, alone and after an insert symbol
      push_item(CMD_NONE, 8'hC3, 1'b1, 1'b0);
      push_item(CMD_NONE, 8'h3C, 1'b0, 1'b1);
      push_item(CMD_INSERT, 8'h12, 1'b1, 1'b0);
      push_item(CMD_NONE, 8'h00, 1'b1, 1'b1);
      push_item(CMD_SEARCH, 8'h12, 1'b1, 1'b1);

      // Random words over a narrow alphabet so paths share prefixes
      while (items_made < 950) begin
         // Exhaust the node pool with long wide-alphabet inserts
         if (!pool_filled && items_made >= 400) begin
            for (int w = 0; w < 22; w++) begin
               for (int k = 0; k < 12; k++) word_buf[k] = 8'($urandom_range(0, 255));
               bank_word(12);
               push_word(CMD_INSERT, 12);
            end
            pool_filled = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) word_buf[k] = narrow_symbol();
            bank_word(len);
            push_word(CMD_INSERT, len);
         end else if (pick < 65 && bank_count > 0) begin
            len = recall_word();
            case ($urandom_range(0, 3))
               0: if (len < WORD_MAX) begin
                  word_buf[len] = narrow_symbol();
                  len = len + 1;
               end
               1: if (len > 0) len = len - 1;
               default: ;
            endcase
            push_word(CMD_SEARCH, len);
         end else if (pick < 80 && bank_count > 0) begin
            len = recall_word();
            push_word(CMD_PREFIX, $urandom_range(0, len));
         end else if (pick < 90) begin
            len = $urandom_range(0, 5);
            for (int k = 0; k < len; k++) word_buf[k] = narrow_symbol();
            push_word($urandom_range(0, 1) ? CMD_SEARCH : CMD_PREFIX, len);
         end else if (pick < 96) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               push_item(command_type'($urandom_range(0, 3)), narrow_symbol(),
                         $urandom_range(0, 3) != 0, k == len - 1);
         end else begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++)
               push_item(CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         k == len - 1);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: every item taken and every owed result seen, then settle
      while (items_accepted < items_made || answers_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("prefix_trie_insert_search: match");
      end else begin
         $display("prefix_trie_insert_search: mismatch");
      end
      $finish;
   end

endmodule
